@@ design/dspt_pkg.sv @@
// ----------------------------------------------------------------------------
// dspt_pkg: shared types and constants for the dual sensor position tracker
// Level quantizer constants, position rule thresholds, lane status word and
// the controller state encoding.
// ----------------------------------------------------------------------------
package dspt_pkg;

    // Quantized level range 0..LEVEL_TOP
    localparam int LEVEL_BITS  = 5;
    localparam int LEVEL_TOP   = 29;

    // Rule thresholds
    localparam int LOW_EDGE    = 2;
    localparam int MID_EDGE    = 1;
    localparam int B_HIGH_EDGE = 18;
    localparam int A_HIGH_EDGE = 25;

    // Position counter width
    localparam int POS_BITS    = 32;

    // Restoring divider: one quotient bit per step
    localparam int QUOT_STEPS  = LEVEL_BITS;
    localparam int STEP_BITS   = $clog2(QUOT_STEPS);

    // Per-lane status toward the controller and merge stage
    typedef struct packed {
        logic                  busy;
        logic                  valid;
        logic [LEVEL_BITS-1:0] level;
    } lane_status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } ctrl_state_t;

endpackage

@@ design/dspt_lane.sv @@
// ----------------------------------------------------------------------------
// dspt_lane: one sensor channel quantizer
// Tracks the running peak of the channel and computes
// floor(sample * 29 / peak) with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module dspt_lane
    import dspt_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] sample,
    output lane_status_t           status
);

    localparam int NUM_W = SAMPLE_BITS + LEVEL_BITS;

    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [NUM_W-1:0]       rem_reg;
    logic [NUM_W-1:0]       div_reg;
    logic [LEVEL_BITS-1:0]  quot_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   busy_reg;
    logic                   valid_reg;

    logic [SAMPLE_BITS-1:0] peak_max;
    logic [NUM_W-1:0]       num;
    logic                   fits;
    logic [NUM_W-1:0]       trial;

    // New peak and scaled numerator for the incoming sample
    assign peak_max = (sample > peak_reg) ? sample : peak_reg;
    assign num      = NUM_W'(sample) * NUM_W'(LEVEL_TOP);

    // One restoring step
    assign fits  = (rem_reg >= div_reg);
    assign trial = rem_reg - div_reg;

    // Peak tracker and divider iteration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else if (start) begin
            peak_reg  <= peak_max;
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end else if (busy_reg && (step_reg == STEP_BITS'(QUOT_STEPS - 1))) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b1;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            div_reg  <= NUM_W'(peak_max) << (QUOT_STEPS - 1);
            quot_reg <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= trial;
            end
            div_reg  <= div_reg >> 1;
            quot_reg <= {quot_reg[LEVEL_BITS-2:0], fits};
            step_reg <= step_reg + STEP_BITS'(1);
        end
    end

    // Zero peak reads as level 0
    always_comb begin
        status.busy  = busy_reg;
        status.valid = valid_reg;
        status.level = (peak_reg == '0) ? '0 : quot_reg;
    end

endmodule

@@ design/dspt_merge.sv @@
// ----------------------------------------------------------------------------
// dspt_merge: combines the two lane levels into a position update
// Holds the previous levels and the saturating position count, picks the
// first matching rule and applies the signed level change.
// ----------------------------------------------------------------------------
module dspt_merge
    import dspt_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       commit,
    input  logic [LEVEL_BITS-1:0]      level_a,
    input  logic [LEVEL_BITS-1:0]      level_b,
    output logic signed [POS_BITS-1:0] position_new,
    output logic                       moved
);

    localparam int DW = LEVEL_BITS + 2;

    logic [LEVEL_BITS-1:0]      last_a_reg;
    logic [LEVEL_BITS-1:0]      last_b_reg;
    logic signed [POS_BITS-1:0] pos_reg;

    logic [LEVEL_BITS:0]   chg_a;
    logic [LEVEL_BITS:0]   chg_b;
    logic [DW-1:0]         delta;
    logic                  changed;
    logic [POS_BITS:0]     sum;

    // Signed level changes (two's complement, one extra bit)
    assign chg_a   = {1'b0, level_a} - {1'b0, last_a_reg};
    assign chg_b   = {1'b0, level_b} - {1'b0, last_b_reg};
    assign changed = (level_a != last_a_reg) || (level_b != last_b_reg);

    // Rule priority
    always_comb begin
        delta = '0;
        if (changed) begin
            if (level_b > level_a && level_b < LEVEL_BITS'(LEVEL_TOP)
                    && level_a < LEVEL_BITS'(LOW_EDGE)) begin
                delta = {chg_b[LEVEL_BITS], chg_b};
            end else if (level_b > level_a && level_a > LEVEL_BITS'(MID_EDGE)
                    && level_b > LEVEL_BITS'(B_HIGH_EDGE)) begin
                delta = {chg_a[LEVEL_BITS], chg_a};
            end else if (level_a > level_b && level_b > LEVEL_BITS'(MID_EDGE)
                    && level_a > LEVEL_BITS'(A_HIGH_EDGE)) begin
                delta = -{chg_b[LEVEL_BITS], chg_b};
            end else if (level_a > level_b && level_a < LEVEL_BITS'(LEVEL_TOP)
                    && level_b < LEVEL_BITS'(LOW_EDGE)) begin
                delta = -{chg_a[LEVEL_BITS], chg_a};
            end
        end
    end

    // Saturating add
    assign sum = {pos_reg[POS_BITS-1], pos_reg}
               + {{(POS_BITS + 1 - DW){delta[DW-1]}}, delta};

    always_comb begin
        if (sum[POS_BITS] != sum[POS_BITS-1]) begin
            position_new = sum[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}}
                                         : {1'b0, {(POS_BITS-1){1'b1}}};
        end else begin
            position_new = sum[POS_BITS-1:0];
        end
    end

    assign moved = (position_new != pos_reg);

    // Tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_a_reg <= '0;
            last_b_reg <= '0;
            pos_reg    <= '0;
        end else if (commit) begin
            last_a_reg <= level_a;
            last_b_reg <= level_b;
            pos_reg    <= position_new;
        end
    end

endmodule

@@ design/dual_sensor_position_tracker_unit.sv @@
// Flow: an accepted input word runs through the 5-step bit-serial divider in
// each lane, the controller waits to see both lanes done, then commits; the
// commit is held while the output word has not been taken. A new word is
// accepted only once the controller is back in idle after the commit.
// Reset: aresetn synchronous active low; clears peaks, previous levels,
// position count and all handshake state.
// ----------------------------------------------------------------------------
// dual_sensor_position_tracker_unit: two-channel level quantizer and tracker
// Two divider lanes quantize each channel against its running peak; the
// merge stage updates a saturating position count from the level changes.
// ----------------------------------------------------------------------------
module dual_sensor_position_tracker_unit
    import dspt_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_BITS-1:0]     s_sample_a,
    input  logic [SAMPLE_BITS-1:0]     s_sample_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LEVEL_BITS-1:0]      m_level_a,
    output logic [LEVEL_BITS-1:0]      m_level_b,
    output logic signed [POS_BITS-1:0] m_position,
    output logic                       m_moved
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    lane_status_t lane_a;
    lane_status_t lane_b;

    logic                       start;
    logic                       commit;
    logic                       m_valid_reg;
    logic [LEVEL_BITS-1:0]      level_a_reg;
    logic [LEVEL_BITS-1:0]      level_b_reg;
    logic signed [POS_BITS-1:0] position_reg;
    logic                       moved_reg;
    logic signed [POS_BITS-1:0] position_new;
    logic                       moved;

    // Lanes
    dspt_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .sample  (s_sample_a),
        .status  (lane_a)
    );

    dspt_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .sample  (s_sample_b),
        .status  (lane_b)
    );

    // Merge stage
    dspt_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .commit       (commit),
        .level_a      (lane_a.level),
        .level_b      (lane_b.level),
        .position_new (position_new),
        .moved        (moved)
    );

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and control
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        start      = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    start      = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (lane_a.valid && lane_b.valid) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            level_a_reg  <= lane_a.level;
            level_b_reg  <= lane_b.level;
            position_reg <= position_new;
            moved_reg    <= moved;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_level_a  = level_a_reg;
    assign m_level_b  = level_b_reg;
    assign m_position = position_reg;
    assign m_moved    = moved_reg;

    // Checks
    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_a.busy == lane_b.busy) && (lane_a.valid == lane_b.valid))
        else $error("lanes out of step");

    a_divide_active: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVIDE |-> (lane_a.busy || lane_a.valid))
        else $error("divide state with idle lane");

    a_ready_lanes_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !lane_a.busy)
        else $error("input ready while lane busy");

    a_load_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("output loaded outside commit");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (level_a_reg <= LEVEL_BITS'(LEVEL_TOP))
                     && (level_b_reg <= LEVEL_BITS'(LEVEL_TOP)))
        else $error("level out of range");

endmodule
